[rtl/core/rla_pkg.sv]
// ----------------------------------------------------------------------------
// rla_pkg
// Shared types, command codes and character constants of the radix literal
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rla_pkg;

   localparam int DEF_VALUE_BITS = 64;
   localparam int CMD_BITS       = 2;
   localparam int CHAR_BITS      = 21;
   localparam int RADIX_BITS     = 2;
   localparam int FACTOR_BITS    = 64;
   localparam int OUT_BITS       = 64;
   localparam int ERR_BITS       = 2;
   localparam int WSEL_BITS      = 2;
   localparam int DIGIT_BITS     = 4;

   // multiply runs over the factor one chunk at a time, top chunk first
   localparam int CHUNK_BITS = 16;
   localparam int MUL_STEPS  = FACTOR_BITS / CHUNK_BITS;
   localparam int STEP_BITS  = $clog2(MUL_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef logic [CMD_BITS-1:0]   cmd_type;
   typedef logic [RADIX_BITS-1:0] radix_type;
   typedef logic [ERR_BITS-1:0]   err_type;
   typedef logic [WSEL_BITS-1:0]  wsel_type;

   localparam cmd_type CMD_CLEAR  = 2'd0;
   localparam cmd_type CMD_DIGIT  = 2'd1;
   localparam cmd_type CMD_MUL    = 2'd2;
   localparam cmd_type CMD_NEGATE = 2'd3;

   localparam radix_type RADIX_BIN = 2'd0;
   localparam radix_type RADIX_OCT = 2'd1;
   localparam radix_type RADIX_DEC = 2'd2;
   localparam radix_type RADIX_HEX = 2'd3;

   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_DIGIT = 2'd1;
   localparam err_type ERR_RANGE = 2'd2;

   localparam wsel_type WSEL_8  = 2'd0;
   localparam wsel_type WSEL_32 = 2'd1;
   localparam wsel_type WSEL_64 = 2'd2;

   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 21'h30;
   localparam logic [CHAR_BITS-1:0] CH_ONE     = 21'h31;
   localparam logic [CHAR_BITS-1:0] CH_SEVEN   = 21'h37;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 21'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 21'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_F = 21'h46;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 21'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_F = 21'h66;

   // a classified word as it waits between front and back
   typedef struct packed {
      cmd_type                 command;
      logic                    digit_ok;
      logic [DIGIT_BITS-1:0]   digit;
      radix_type               radix_select;
      logic [FACTOR_BITS-1:0]  factor;
   } entry_type;

endpackage

`default_nettype wire

[rtl/core/rla_front.sv]
// ----------------------------------------------------------------------------
// rla_front
// Accepts request words and classifies the character against the radix.
// ----------------------------------------------------------------------------
`default_nettype none

module rla_front (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire rla_pkg::cmd_type              req_command,
   input  wire logic [rla_pkg::CHAR_BITS-1:0] req_character,
   input  wire rla_pkg::radix_type            req_radix_select,
   input  wire logic [rla_pkg::FACTOR_BITS-1:0] req_factor,
   input  wire logic                          q_full,
   output logic                               push_valid,
   output rla_pkg::entry_type                 push_entry
);
   import rla_pkg::*;

   logic                  is_num;
   logic                  is_upper;
   logic                  is_lower;
   logic                  ok;
   logic [DIGIT_BITS-1:0] num_val;
   logic [DIGIT_BITS-1:0] upper_val;
   logic [DIGIT_BITS-1:0] lower_val;
   logic [DIGIT_BITS-1:0] dval;

   assign is_num   = (req_character >= CH_ZERO)    && (req_character <= CH_NINE);
   assign is_upper = (req_character >= CH_UPPER_A) && (req_character <= CH_UPPER_F);
   assign is_lower = (req_character >= CH_LOWER_A) && (req_character <= CH_LOWER_F);

   assign num_val   = DIGIT_BITS'(req_character - CH_ZERO);
   assign upper_val = DIGIT_BITS'(req_character - CH_UPPER_A + 21'd10);
   assign lower_val = DIGIT_BITS'(req_character - CH_LOWER_A + 21'd10);

   always_comb begin
      dval = num_val;
      unique case (req_radix_select)
         RADIX_BIN: begin
            ok = (req_character >= CH_ZERO) && (req_character <= CH_ONE);
         end
         RADIX_OCT: begin
            ok = (req_character >= CH_ZERO) && (req_character <= CH_SEVEN);
         end
         RADIX_DEC: begin
            ok = is_num;
         end
         default: begin
            ok = is_num || is_upper || is_lower;
            if (is_upper) begin
               dval = upper_val;
            end else if (is_lower) begin
               dval = lower_val;
            end
         end
      endcase
   end

   assign req_ready  = !q_full;
   assign push_valid = req_valid && !q_full;

   always_comb begin
      push_entry.command      = req_command;
      push_entry.digit_ok     = ok;
      push_entry.digit        = dval;
      push_entry.radix_select = req_radix_select;
      push_entry.factor       = req_factor;
   end

endmodule

`default_nettype wire

[rtl/core/rla_queue.sv]
// ----------------------------------------------------------------------------
// rla_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rla_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire rla_pkg::entry_type push_entry,
   output logic                    q_full,
   output logic                    q_valid,
   output rla_pkg::entry_type      q_entry,
   input  wire logic               q_pop
);
   import rla_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_full  = (count_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && !q_full;
   assign do_pop  = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rla_back.sv]
// ----------------------------------------------------------------------------
// rla_back
// Executes queued words against the accumulator and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rla_back #(
   parameter int VALUE_BITS = rla_pkg::DEF_VALUE_BITS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_valid,
   input  wire rla_pkg::entry_type           q_entry,
   output logic                              q_pop,
   input  wire rla_pkg::wsel_type            width_select,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [rla_pkg::OUT_BITS-1:0]      rsp_value,
   output rla_pkg::err_type                  rsp_error_code
);
   import rla_pkg::*;

   localparam int PW = VALUE_BITS + FACTOR_BITS;
   localparam int SW = VALUE_BITS + 4;
   localparam int MW = VALUE_BITS + CHUNK_BITS;
   localparam logic [6:0] VB7 = 7'(VALUE_BITS);
   localparam logic [VALUE_BITS-1:0] ONES = '1;
   localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MUL_STEPS - 1);

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0]   out_value_ff, out_value_in;
   err_type               out_err_ff, out_err_in;

   logic [6:0]            w_raw;
   logic [6:0]            w_eff;
   logic [VALUE_BITS-1:0] mask;
   logic [VALUE_BITS-1:0] msb;
   logic                  over_max;
   logic [SW-1:0]         acc_ext;
   logic [SW-1:0]         scaled;
   logic [SW-1:0]         dsum;
   logic                  dig_ovf;
   logic                  mul_ovf;
   logic [CHUNK_BITS-1:0] chunk;
   logic [MW-1:0]         partial;
   logic                  out_free;
   logic                  is_mul;
   logic                  fire;
   err_type               err;

   always_comb begin
      unique case (width_select)
         WSEL_8:  w_raw = 7'd8;
         WSEL_32: w_raw = 7'd32;
         default: w_raw = 7'd64;
      endcase
   end

   assign w_eff    = (w_raw > VB7) ? VB7 : w_raw;
   assign mask     = ONES >> (VB7 - w_eff);
   assign msb      = mask & ~(mask >> 1);
   assign over_max = |(acc_ff & ~mask);

   // digit step: acc*radix + digit, exact in four extra bits
   assign acc_ext = SW'(acc_ff);
   always_comb begin
      unique case (q_entry.radix_select)
         RADIX_BIN: scaled = acc_ext << 1;
         RADIX_OCT: scaled = acc_ext << 3;
         RADIX_DEC: scaled = (acc_ext << 3) + (acc_ext << 1);
         default:   scaled = acc_ext << 4;
      endcase
   end
   assign dsum    = scaled + SW'(q_entry.digit);
   assign dig_ovf = |(dsum & ~SW'(mask));

   // multiply-accumulate over factor chunks, most significant first
   assign chunk   = q_entry.factor[(LAST_STEP - step_ff)*CHUNK_BITS +: CHUNK_BITS];
   assign partial = MW'(acc_ff) * MW'(chunk);
   assign mul_ovf = |(prod_ff & ~PW'(mask));

   assign is_mul   = (q_entry.command == CMD_MUL);
   assign out_free = !out_valid_ff || rsp_ready;
   assign fire     = q_valid && out_free && (!is_mul || done_ff);
   assign q_pop    = fire;

   always_comb begin
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      err          = ERR_NONE;

      if (busy_ff) begin
         prod_in = (prod_ff << CHUNK_BITS) + PW'(partial);
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (q_valid && is_mul && !done_ff) begin
         busy_in = 1'b1;
         step_in = '0;
         prod_in = '0;
      end

      if (fire) begin
         unique case (q_entry.command)
            CMD_CLEAR: begin
               acc_in = '0;
            end
            CMD_DIGIT: begin
               if (!q_entry.digit_ok) begin
                  err = ERR_DIGIT;
               end else if (dig_ovf) begin
                  err = ERR_RANGE;
               end else begin
                  acc_in = dsum[VALUE_BITS-1:0];
               end
            end
            CMD_MUL: begin
               done_in = 1'b0;
               if (mul_ovf) begin
                  err = ERR_RANGE;
               end else begin
                  acc_in = prod_ff[VALUE_BITS-1:0];
               end
            end
            default: begin
               if (over_max || (acc_ff == msb)) begin
                  err = ERR_RANGE;
               end else begin
                  acc_in = (-acc_ff) & mask;
               end
            end
         endcase
         out_valid_in = 1'b1;
         out_value_in = OUT_BITS'(acc_in);
         out_err_in   = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         step_ff      <= '0;
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_error_code = out_err_ff;

endmodule

`default_nettype wire

[rtl/core/radix_literal_accumulator.sv]
// ----------------------------------------------------------------------------
// radix_literal_accumulator
// Builds an unsigned literal from character codes, one word per command:
// clear, enter digit (radix 2, 8, 10 or 16), multiply by a 64-bit factor and
// negate, each bounded by the 8, 32 or 64 bit width set in csr_width_select
// (reset 64). Every request word gives one response word with the
// accumulator value and an error code; a bad digit or an out-of-range result
// keeps the accumulator. Clear, digit and negate words run at one per cycle
// while the response is not stalled; a multiply holds the execute stage as
// it clears the product register, runs four multiply-accumulate steps of a
// 64x16 multiplier over the factor and does the range check and write-back.
// A request word passes through the queue and its result through the output
// register. A two-word queue separates request acceptance from execution,
// and the response sits in an output register so a new word can be taken
// while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_literal_accumulator #(
   parameter int VALUE_BITS = rla_pkg::DEF_VALUE_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [rla_pkg::CMD_BITS-1:0]    req_command,
   input  wire logic [rla_pkg::CHAR_BITS-1:0]   req_character,
   input  wire logic [rla_pkg::RADIX_BITS-1:0]  req_radix_select,
   input  wire logic [rla_pkg::FACTOR_BITS-1:0] req_factor,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [rla_pkg::OUT_BITS-1:0]         rsp_value,
   output logic [rla_pkg::ERR_BITS-1:0]         rsp_error_code,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rla_pkg::WSEL_BITS-1:0]   csr_width_select
);
   import rla_pkg::*;

   wsel_type  width_ff, width_in;
   logic      push_valid;
   entry_type push_entry;
   logic      q_full;
   logic      q_valid;
   entry_type q_entry;
   logic      q_pop;

   assign csr_ready = 1'b1;
   assign width_in  = csr_valid ? csr_width_select : width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WSEL_64;
      end else begin
         width_ff <= width_in;
      end
   end

   rla_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_character    (req_character),
      .req_radix_select (req_radix_select),
      .req_factor       (req_factor),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   rla_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   rla_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .width_select   (width_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_error_code (rsp_error_code)
   );

endmodule

`default_nettype wire

[rtl/core/rla_checker.sv]
// ----------------------------------------------------------------------------
// rla_checker
// Port-level checks on the radix literal accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rla_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [rla_pkg::OUT_BITS-1:0]    rsp_value,
   input wire logic [rla_pkg::ERR_BITS-1:0]    rsp_error_code,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready
);
   import rla_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word right after reset");

   // a stalled response word keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
                                  && $stable(rsp_error_code))
      else $error("stalled response word changed");

   // only defined error codes are reported
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_code == ERR_NONE) || (rsp_error_code == ERR_DIGIT)
                    || (rsp_error_code == ERR_RANGE))
      else $error("undefined error code");

   // register writes are never held off
   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind radix_literal_accumulator rla_checker u_rla_checker (.*);

`default_nettype wire

[dv/radix_literal_accumulator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_literal_accumulator_test
// Self-checking bench for the literal accumulator. A queue of request words
// feeds a clocked driver, and each accepted word is run through a local
// model of the accumulator to predict its response. A clocked monitor
// compares every response word against the oldest prediction. A directed
// opening covers every command, every radix and its top digit. Nine random
// phases follow, each writing the width, with a new stall pattern every third.
// ----------------------------------------------------------------------------

module radix_literal_accumulator_test;
   import rla_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [CHAR_BITS-1:0] CHAR_TOP = 21'h10FFFF;
   localparam logic [FACTOR_BITS-1:0] FACTOR_ONES = {FACTOR_BITS{1'b1}};

   typedef struct {
      cmd_type                command;
      logic [CHAR_BITS-1:0]   character;
      radix_type              radix_select;
      logic [FACTOR_BITS-1:0] factor;
   } literal_word_type;

   typedef struct {
      logic [OUT_BITS-1:0] value;
      err_type             error_code;
   } literal_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cmd_type                req_command = CMD_CLEAR;
   logic [CHAR_BITS-1:0]   req_character = '0;
   radix_type              req_radix_select = RADIX_BIN;
   logic [FACTOR_BITS-1:0] req_factor = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OUT_BITS-1:0]    rsp_value;
   err_type                rsp_error_code;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   wsel_type               csr_width_select = WSEL_64;

   literal_word_type   queued_words[$];
   literal_result_type awaited_literals[$];

   // model state, mirrors the accumulator and its width register
   logic [63:0] literal_accum = '0;
   wsel_type    active_width_sel = WSEL_64;

   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   radix_literal_accumulator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_character    (req_character),
      .req_radix_select (req_radix_select),
      .req_factor       (req_factor),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_width_select (csr_width_select)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at %0t: %s, got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic literal_result_type next_literal(input literal_word_type w);
      literal_result_type res;
      int unsigned     width_bits;
      logic [63:0]     limit;
      logic [127:0]    wide;
      logic [4:0]      radix_n;
      logic [4:0]      digit;
      logic            is_digit;
      logic            is_dec;
      logic            is_upper;
      logic            is_lower;
      width_bits = (active_width_sel == WSEL_8) ? 8 : (active_width_sel == WSEL_32) ? 32 : 64;
      limit = (width_bits == 64) ? {64{1'b1}} : ((64'd1 << width_bits) - 64'd1);
      res.error_code = ERR_NONE;
      case (w.command)
         CMD_CLEAR: begin
            literal_accum = '0;
         end
         CMD_DIGIT: begin
            is_dec   = w.character >= CH_ZERO && w.character <= CH_NINE;
            is_upper = w.character >= CH_UPPER_A && w.character <= CH_UPPER_F;
            is_lower = w.character >= CH_LOWER_A && w.character <= CH_LOWER_F;
            if (is_dec)
               digit = 5'(w.character - CH_ZERO);
            else if (is_upper)
               digit = 5'(w.character - CH_UPPER_A + 10);
            else
               digit = 5'(w.character - CH_LOWER_A + 10);
            case (w.radix_select)
               RADIX_BIN: begin
                  radix_n = 5'd2;
                  is_digit = w.character >= CH_ZERO && w.character <= CH_ONE;
               end
               RADIX_OCT: begin
                  radix_n = 5'd8;
                  is_digit = w.character >= CH_ZERO && w.character <= CH_SEVEN;
               end
               RADIX_DEC: begin
                  radix_n = 5'd10;
                  is_digit = is_dec;
               end
               default: begin
                  radix_n = 5'd16;
                  is_digit = is_dec || is_upper || is_lower;
               end
            endcase
            // a bad character wins over a range error
            if (!is_digit) begin
               res.error_code = ERR_DIGIT;
            end else begin
               wide = {64'd0, literal_accum} * {123'd0, radix_n} + {123'd0, digit};
               if (wide > {64'd0, limit})
                  res.error_code = ERR_RANGE;
               else
                  literal_accum = wide[63:0];
            end
         end
         CMD_MUL: begin
            wide = {64'd0, literal_accum} * {64'd0, w.factor};
            if (w.factor == '0)
               literal_accum = '0;
            else if (wide > {64'd0, limit})
               res.error_code = ERR_RANGE;
            else
               literal_accum = wide[63:0];
         end
         default: begin
            if (literal_accum > limit || literal_accum == (64'd1 << (width_bits - 1)))
               res.error_code = ERR_RANGE;
            else
               literal_accum = (~literal_accum + 64'd1) & limit;
         end
      endcase
      res.value = literal_accum;
      return res;
   endfunction

   task automatic push_word(input cmd_type cmd, input logic [CHAR_BITS-1:0] ch,
                            input radix_type rs, input logic [FACTOR_BITS-1:0] factor);
      literal_word_type w;
      w.command = cmd;
      w.character = ch;
      w.radix_select = rs;
      w.factor = factor;
      queued_words.push_back(w);
   endtask

   function automatic logic [CHAR_BITS-1:0] random_char();
      if ($urandom_range(1))
         return CHAR_BITS'($urandom_range(127));
      return CHAR_BITS'($urandom_range(CHAR_TOP));
   endfunction

   function automatic logic [FACTOR_BITS-1:0] random_factor();
      case ($urandom_range(3))
         0: return FACTOR_BITS'($urandom_range(20));
         1: return 64'd1 << $urandom_range(63);
         2: return {$urandom, $urandom};
         default: return FACTOR_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(input radix_type rs);
      int unsigned d;
      case (rs)
         RADIX_BIN: d = $urandom_range(1);
         RADIX_OCT: d = $urandom_range(7);
         RADIX_DEC: d = $urandom_range(9);
         default:   d = $urandom_range(15);
      endcase
      if (d < 10)
         return CHAR_BITS'(CH_ZERO + d);
      if ($urandom_range(1))
         return CHAR_BITS'(CH_UPPER_A + d - 10);
      return CHAR_BITS'(CH_LOWER_A + d - 10);
   endfunction

   // mostly well-formed literals: clear, a run of digits, then at times a
   // multiply or negate; the rest is loose commands and noise words
   task automatic queue_random_words(input int count);
      int        made;
      int        pick;
      int        digits;
      radix_type rs;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            rs = radix_type'($urandom_range(3));
            push_word(CMD_CLEAR, random_char(), rs, random_factor());
            digits = ($urandom_range(3) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            repeat (digits) push_word(CMD_DIGIT, digit_char(rs), rs, random_factor());
            made += digits + 1;
            if ($urandom_range(1)) begin
               push_word($urandom_range(1) ? CMD_MUL : CMD_NEGATE, random_char(), rs,
                         random_factor());
               made++;
            end
         end else if (pick < 70) begin
            push_word(CMD_MUL, random_char(), radix_type'($urandom_range(3)), random_factor());
            made++;
         end else if (pick < 80) begin
            push_word(CMD_NEGATE, random_char(), radix_type'($urandom_range(3)),
                      random_factor());
            made++;
         end else begin
            push_word(cmd_type'($urandom_range(3)), random_char(),
                      radix_type'($urandom_range(3)), {$urandom, $urandom});
            made++;
         end
      end
   endtask

   // checked between edges so the driver's updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (queued_words.size() != 0 || req_valid || awaited_literals.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_width(input wsel_type sel);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_width_select <= sel;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      active_width_sel = sel;
   endtask

   always @(posedge clock) begin : req_driver
      literal_word_type sent_word;
      literal_word_type next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sent_word.command = req_command;
            sent_word.character = req_character;
            sent_word.radix_select = req_radix_select;
            sent_word.factor = req_factor;
            awaited_literals.push_back(next_literal(sent_word));
         end
         if (!req_valid || req_ready) begin
            if (queued_words.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
               next_word = queued_words.pop_front();
               req_valid <= 1'b1;
               req_command <= next_word.command;
               req_character <= next_word.character;
               req_radix_select <= next_word.radix_select;
               req_factor <= next_word.factor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      literal_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_literals.size() == 0) begin
               report_mismatch("response word with none expected", rsp_value, '0);
            end else begin
               want = awaited_literals.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch("value", rsp_value, want.value);
               if (rsp_error_code !== want.error_code)
                  report_mismatch("error_code", 64'(rsp_error_code), 64'(want.error_code));
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("radix_literal_accumulator regression: fail");
         $finish;
      end
   end

   initial begin
      sender_gap_pct = 18;
      receiver_stall_pct = 49;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset width of 64 bits
      push_word(CMD_NEGATE, '0, RADIX_HEX, '0);
      push_word(CMD_DIGIT, CH_ONE, RADIX_BIN, FACTOR_ONES);
      push_word(CMD_DIGIT, CH_ONE + 21'd1, RADIX_BIN, '0);
      push_word(CMD_DIGIT, CH_SEVEN, RADIX_OCT, '0);
      push_word(CMD_DIGIT, CH_SEVEN + 21'd1, RADIX_OCT, '0);
      push_word(CMD_DIGIT, CH_NINE, RADIX_DEC, '0);
      push_word(CMD_DIGIT, CH_ZERO - 21'd1, RADIX_DEC, '0);
      push_word(CMD_DIGIT, CH_LOWER_F, RADIX_HEX, '0);
      push_word(CMD_DIGIT, CH_UPPER_F + 21'd1, RADIX_HEX, '0);
      // a digit code with upper bits set is not a digit
      push_word(CMD_DIGIT, CH_ZERO | 21'h10000, RADIX_HEX, '0);
      push_word(CMD_MUL, '0, RADIX_BIN, FACTOR_ONES);
      push_word(CMD_MUL, '0, RADIX_BIN, '0);
      push_word(CMD_DIGIT, CH_ONE, RADIX_DEC, '0);
      push_word(CMD_MUL, '0, RADIX_DEC, FACTOR_ONES);
      push_word(CMD_DIGIT, CH_ZERO, RADIX_HEX, '0);
      push_word(CMD_CLEAR, '0, RADIX_BIN, '0);
      push_word(CMD_DIGIT, CH_ONE, RADIX_BIN, '0);
      push_word(CMD_MUL, '0, RADIX_HEX, 64'd1 << 63);
      // most negative value cannot be negated
      push_word(CMD_NEGATE, CHAR_TOP, RADIX_HEX, '0);
      wait_drained();

      // narrow to 8 bits with 2^63 still held
      write_width(WSEL_8);
      push_word(CMD_DIGIT, CH_ONE, RADIX_BIN, '0);
      push_word(CMD_DIGIT, CH_LOWER_F + 21'd1, RADIX_HEX, '0);
      push_word(CMD_MUL, '0, RADIX_BIN, 64'd1);
      push_word(CMD_NEGATE, '0, RADIX_BIN, '0);
      push_word(CMD_MUL, '0, RADIX_BIN, '0);
      push_word(CMD_DIGIT, CH_UPPER_F, RADIX_HEX, '0);
      push_word(CMD_MUL, '0, RADIX_HEX, 64'd17);
      push_word(CMD_DIGIT, CH_ZERO, RADIX_BIN, '0);
      push_word(CMD_CLEAR, CHAR_TOP, RADIX_HEX, FACTOR_ONES);
      push_word(CMD_DIGIT, CH_ZERO + 21'd8, RADIX_HEX, '0);
      push_word(CMD_MUL, '0, RADIX_HEX, 64'd16);
      push_word(CMD_NEGATE, '0, RADIX_HEX, '0);
      wait_drained();

      // random phases; the accumulator is kept across width changes
      for (int p = 0; p < 9; p++) begin
         sender_gap_pct = (p < 3) ? 18 : (p < 6) ? 49 : 0;
         receiver_stall_pct = (p < 3) ? 49 : (p < 6) ? 18 : 0;
         write_width(wsel_type'(p % 4));
         queue_random_words(38);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (awaited_literals.size() != 0)
         report_mismatch("response words never arrived", 64'(awaited_literals.size()), '0);
      if (mismatch_count == 0) begin
         $display("radix_literal_accumulator regression: pass");
      end else begin
         $display("radix_literal_accumulator regression: fail");
      end
      $finish;
   end

endmodule

[radix_literal_accumulator.f]
rtl/core/rla_pkg.sv
rtl/core/rla_front.sv
rtl/core/rla_queue.sv
rtl/core/rla_back.sv
rtl/core/radix_literal_accumulator.sv
rtl/core/rla_checker.sv
dv/radix_literal_accumulator_test.sv
